// ----- rtl/rbht_pkg.sv -----
// Shared types and constants for the random byte block health test.
`default_nettype none
package rbht_pkg;

    localparam int BYTE_W = 8;
    localparam int ONES_W = 14;
    localparam int RUN_W  = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int M_DATA_W    = 32;

    localparam int ONES_MAX = 16383;
    localparam int RUN_MAX  = 1023;

    localparam int BLOCK_BYTES_DEFAULT = 1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_ONES  = 2'd0,
        CFG_MAX_ONES  = 2'd1,
        CFG_RUN_LIMIT = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        REASON_NONE      = 2'd0,
        REASON_CONSTANT  = 2'd1,
        REASON_IMBALANCE = 2'd2,
        REASON_LONG_RUN  = 2'd3
    } reason_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] sample_byte;
        logic              last_byte;
    } beat_t;

    typedef struct packed {
        logic [ONES_W-1:0] min_ones;
        logic [ONES_W-1:0] max_ones;
        logic [RUN_W-1:0]  run_limit;
    } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/rbht_ingress.sv -----
// Input register stage that captures one sample beat per cycle while the tracker keeps advancing.
`default_nettype none
module rbht_ingress
    import rbht_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // sample_byte
    input  wire logic              s_tlast,
    input  wire logic              advance,
    output beat_t                  beat
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign beat.valid       = valid_reg;
    assign beat.sample_byte = byte_reg;
    assign beat.last_byte   = last_reg;

endmodule
`default_nettype wire

// ----- rtl/rbht_tracker.sv -----
// Block statistics, verdict logic and the result register.
`default_nettype none
module rbht_tracker
    import rbht_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire beat_t               beat,
    input  wire cfg_t                cfg,
    output logic                     advance,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata   // passed, fail_reason, ones_total, longest_run
);

    logic [BYTE_W-1:0] prev_reg;
    logic [BYTE_W-1:0] prev_next;
    logic              have_prev_reg;
    logic              have_prev_next;
    logic              zero_only_reg;
    logic              zero_only_next;
    logic              all_ff_reg;
    logic              all_ff_next;
    logic [ONES_W-1:0] ones_reg;
    logic [ONES_W-1:0] ones_next;
    logic [RUN_W-1:0]  run_reg;
    logic [RUN_W-1:0]  run_next;
    logic [RUN_W-1:0]  best_reg;
    logic [RUN_W-1:0]  best_next;

    logic [3:0]        pop;
    logic [ONES_W:0]   ones_sum;
    logic [ONES_W-1:0] ones_upd;
    logic [RUN_W-1:0]  run_upd;
    logic [RUN_W-1:0]  best_upd;
    logic              zero_upd;
    logic              ff_upd;
    reason_t           reason;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;

    assign advance = beat.valid && (!beat.last_byte || !out_valid_reg || m_tready);

    always_comb begin
        pop = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            pop = pop + 4'(beat.sample_byte[i]);
        end
    end

    always_comb begin
        zero_upd = zero_only_reg && (beat.sample_byte == 8'h00);
        ff_upd   = all_ff_reg && (beat.sample_byte == 8'hFF);
        ones_sum = {1'b0, ones_reg} + (ONES_W+1)'(pop);
        ones_upd = (ones_sum > (ONES_W+1)'(ONES_MAX)) ? ONES_W'(ONES_MAX)
                                                       : ones_sum[ONES_W-1:0];
        if (have_prev_reg && (beat.sample_byte == prev_reg)) begin
            run_upd = (run_reg < RUN_W'(RUN_MAX)) ? run_reg + 1'b1 : run_reg;
        end else begin
            run_upd = '0;
        end
        best_upd = (run_upd > best_reg) ? run_upd : best_reg;

        if (zero_upd || ff_upd) begin
            reason = REASON_CONSTANT;
        end else if ((ones_upd < cfg.min_ones) || (ones_upd > cfg.max_ones)) begin
            reason = REASON_IMBALANCE;
        end else if (best_upd > cfg.run_limit) begin
            reason = REASON_LONG_RUN;
        end else begin
            reason = REASON_NONE;
        end
    end

    always_comb begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        zero_only_next = zero_only_reg;
        all_ff_next    = all_ff_reg;
        ones_next      = ones_reg;
        run_next       = run_reg;
        best_next      = best_reg;
        if (advance) begin
            if (beat.last_byte) begin
                prev_next      = '0;
                have_prev_next = 1'b0;
                zero_only_next = 1'b1;
                all_ff_next    = 1'b1;
                ones_next      = '0;
                run_next       = '0;
                best_next      = '0;
            end else begin
                prev_next      = beat.sample_byte;
                have_prev_next = 1'b1;
                zero_only_next = zero_upd;
                all_ff_next    = ff_upd;
                ones_next      = ones_upd;
                run_next       = run_upd;
                best_next      = best_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            zero_only_reg <= 1'b1;
            all_ff_reg    <= 1'b1;
            ones_reg      <= '0;
            run_reg       <= '0;
            best_reg      <= '0;
        end else begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            zero_only_reg <= zero_only_next;
            all_ff_reg    <= all_ff_next;
            ones_reg      <= ones_next;
            run_reg       <= run_next;
            best_reg      <= best_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (advance && beat.last_byte) begin
            out_valid_next = 1'b1;
            out_data_next  = {5'b0, best_upd, ones_upd, reason,
                              (reason == REASON_NONE)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ----- rtl/rng_block_health_test.sv -----
// Top level of the random byte block health test.
//
// Random bytes arrive one per beat on the s_ channel, with s_tlast on the
// final byte of a block. The block tracks constant data, the set-bit count and
// the longest run of repeated bytes, and on the final byte sends one verdict
// beat on the m_ channel. Non-final bytes produce no output beat.
// Throughput is one byte per cycle unless a final byte waits on a stalled
// receiver. A verdict reaches m_tvalid via the result register as its final
// byte leaves the input register. The user writes the three thresholds on the
// cfg_ channel only while the block is idle; the block does not enforce this.
// cfg_ready is always high. Reset clears the block statistics and loads the
// thresholds from BLOCK_BYTES. When the receiver stalls, the verdict holds in
// the result register and only a following final byte waits; other bytes keep
// flowing, so the source sees no back pressure until a second verdict is due.
`default_nettype none
module rng_block_health_test
    import rbht_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,   // sample_byte
    input  wire logic                   s_tlast,   // last_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_W-1:0]         m_tdata,   // passed, fail_reason, ones_total, longest_run
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MinOnesRaw  = (BLOCK_BYTES * 16 + 4) / 5;
    localparam int MaxOnesRaw  = (BLOCK_BYTES * 24) / 5;
    localparam int RunLimitRaw = BLOCK_BYTES / 20;
    localparam logic [ONES_W-1:0] MinOnesInit =
        (MinOnesRaw > ONES_MAX) ? ONES_W'(ONES_MAX) : ONES_W'(MinOnesRaw);
    localparam logic [ONES_W-1:0] MaxOnesInit =
        (MaxOnesRaw > ONES_MAX) ? ONES_W'(ONES_MAX) : ONES_W'(MaxOnesRaw);
    localparam logic [RUN_W-1:0] RunLimitInit =
        (RunLimitRaw > RUN_MAX) ? RUN_W'(RUN_MAX) : RUN_W'(RunLimitRaw);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    beat_t beat;
    logic  advance;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_ONES:  cfg_next.min_ones  = cfg_data[ONES_W-1:0];
                CFG_MAX_ONES:  cfg_next.max_ones  = cfg_data[ONES_W-1:0];
                CFG_RUN_LIMIT: cfg_next.run_limit = cfg_data[RUN_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_ones  <= MinOnesInit;
            cfg_reg.max_ones  <= MaxOnesInit;
            cfg_reg.run_limit <= RunLimitInit;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rbht_ingress u_ingress (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .advance  (advance),
        .beat     (beat)
    );

    rbht_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat     (beat),
        .cfg      (cfg_reg),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the random byte block health test.
module testbench;
    import rbht_pkg::*;

    typedef struct {
        logic              passed;
        reason_t           reason;
        logic [ONES_W-1:0] ones;
        logic [RUN_W-1:0]  run;
    } verdict_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [ONES_W-1:0]      thr_min_ones;
    logic [ONES_W-1:0]      thr_max_ones;
    logic [RUN_W-1:0]       thr_run_limit;

    logic [BYTE_W-1:0]      prev_byte;
    logic                   have_prev;
    logic                   zero_only;
    logic                   all_ff;
    logic [ONES_W-1:0]      ones_cnt;
    logic [RUN_W-1:0]       cur_run;
    logic [RUN_W-1:0]       best_run;

    verdict_t               pending_verdicts[$];
    int                     mismatch_count = 0;
    int                     snd_idle_pct = 0;
    int                     rcv_stall_pct = 0;

    rng_block_health_test DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    function automatic void clear_block_stats();
        prev_byte = '0;
        have_prev = 1'b0;
        zero_only = 1'b1;
        all_ff    = 1'b1;
        ones_cnt  = '0;
        cur_run   = '0;
        best_run  = '0;
    endfunction

    function automatic void load_reset_thresholds();
        int bytes;
        int lo;
        int hi;
        int rl;
        bytes = BLOCK_BYTES_DEFAULT;
        lo = (bytes * 16 + 4) / 5;
        hi = (bytes * 24) / 5;
        rl = bytes / 20;
        thr_min_ones  = (lo > ONES_MAX) ? ONES_W'(ONES_MAX) : ONES_W'(lo);
        thr_max_ones  = (hi > ONES_MAX) ? ONES_W'(ONES_MAX) : ONES_W'(hi);
        thr_run_limit = (rl > RUN_MAX) ? RUN_W'(RUN_MAX) : RUN_W'(rl);
    endfunction

    function automatic void score_byte(logic [BYTE_W-1:0] b, logic last);
        int sum;
        verdict_t v;
        sum = ones_cnt;
        for (int i = 0; i < BYTE_W; i++) begin
            sum += b[i];
        end
        if (b != 8'h00) zero_only = 1'b0;
        if (b != 8'hFF) all_ff = 1'b0;
        ones_cnt = (sum > ONES_MAX) ? ONES_W'(ONES_MAX) : ONES_W'(sum);
        if (have_prev && b == prev_byte) begin
            if (cur_run < RUN_W'(RUN_MAX)) cur_run = cur_run + 1'b1;
        end else begin
            cur_run = '0;
        end
        if (cur_run > best_run) best_run = cur_run;
        prev_byte = b;
        have_prev = 1'b1;
        if (last) begin
            if (zero_only || all_ff) begin
                v.reason = REASON_CONSTANT;
            end else if (ones_cnt < thr_min_ones || ones_cnt > thr_max_ones) begin
                v.reason = REASON_IMBALANCE;
            end else if (best_run > thr_run_limit) begin
                v.reason = REASON_LONG_RUN;
            end else begin
                v.reason = REASON_NONE;
            end
            v.passed = (v.reason == REASON_NONE);
            v.ones   = ones_cnt;
            v.run    = best_run;
            pending_verdicts.push_back(v);
            clear_block_stats();
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict beat, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                check_field("passed", 16'(want.passed), 16'(m_tdata[0]));
                check_field("fail_reason", 16'(want.reason), 16'(m_tdata[2:1]));
                check_field("ones_total", 16'(want.ones), 16'(m_tdata[16:3]));
                check_field("longest_run", 16'(want.run), 16'(m_tdata[26:17]));
            end
        end
    end

    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        score_byte(b, last);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MIN_ONES: begin
                thr_min_ones = value;
            end
            CFG_MAX_ONES: begin
                thr_max_ones = value;
            end
            default: begin
                thr_run_limit = value[RUN_W-1:0];
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(int lo, int hi, int rl);
        drain();
        write_threshold(CFG_MIN_ONES, CFG_DATA_W'(lo));
        write_threshold(CFG_MAX_ONES, CFG_DATA_W'(hi));
        write_threshold(CFG_RUN_LIMIT, CFG_DATA_W'(rl));
    endtask

    task automatic test_reset_thresholds();
        for (int i = 0; i < BLOCK_BYTES_DEFAULT; i++) begin
            send_byte(BYTE_W'($urandom), i == BLOCK_BYTES_DEFAULT - 1);
        end
        for (int i = 0; i < BLOCK_BYTES_DEFAULT; i++) begin
            send_byte(8'h0F, i == BLOCK_BYTES_DEFAULT - 1);
        end
    endtask

    task automatic test_count_saturation();
        for (int i = 0; i < 2100; i++) begin
            send_byte(8'hFF, 1'b0);
        end
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_single_byte_blocks();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_constant_blocks();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_threshold_edges();
        set_thresholds(0, ONES_MAX, RUN_MAX);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h00, 1'b1);
        set_thresholds(ONES_MAX, 0, 0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'hFF, 1'b1);
        set_thresholds(8, 8, 0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF1, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_random_blocks(int snd_pct, int rcv_pct, int items);
        int sent;
        int len;
        int mode;
        logic [BYTE_W-1:0] b;
        set_thresholds($urandom_range(0, 24), $urandom_range(16, 64), $urandom_range(0, 3));
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        sent = 0;
        while (sent < items) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            mode = $urandom_range(7);
            b    = BYTE_W'($urandom);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: begin
                        b = 8'h00;
                    end
                    1: begin
                        b = 8'hFF;
                    end
                    2: begin
                        if ($urandom_range(3) == 0) b = BYTE_W'($urandom);
                    end
                    3: begin
                        b = BYTE_W'($urandom & $urandom);
                    end
                    4: begin
                        b = BYTE_W'($urandom | $urandom);
                    end
                    default: begin
                        b = BYTE_W'($urandom);
                    end
                endcase
                send_byte(b, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_ONES;
        cfg_data  = '0;
        load_reset_thresholds();
        clear_block_stats();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_thresholds();
        test_count_saturation();
        test_single_byte_blocks();
        test_constant_blocks();
        test_threshold_edges();
        test_random_blocks(0, 0, 125);
        test_random_blocks(83, 0, 125);
        test_random_blocks(0, 83, 125);
        test_random_blocks(31, 31, 125);
        drain();

        if (mismatch_count == 0) begin
            $display("rng_block_health_test regression: pass");
        end else begin
            $display("rng_block_health_test regression: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("rng_block_health_test regression: fail");
        $finish;
    end

endmodule
